/* design/rrs_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the scheduler.
`default_nettype none

package rrs_pkg;

  localparam int MAX_PROCS = 8;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  localparam int KIND_W  = 2;
  localparam int PID_W   = 8;
  localparam int ARR_W   = 12;
  localparam int BURST_W = 8;
  localparam int TIME_W  = 16;
  localparam int QNT_W   = 8;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RUN   = 2'd2;

  localparam logic [APB_ADDR_W-3:0] REG_QUANTUM   = '0;
  localparam logic [QNT_W-1:0]      QUANTUM_RESET = 8'd4;

  typedef struct packed {
    logic do_clear;      // empty table, queue and counters
    logic do_load;       // append a process if allowed
    logic run_begin;     // a run word was taken
    logic scan_step;     // one entry of the table scan
    logic scan_limited;  // scan only arrivals at or before the limit
    logic limit_sel;     // 0: limit is current time, 1: slice finish
    logic time_jump;     // move time to the earliest pending arrival
    logic admit_push;    // queue the scan winner
    logic slice_setup;   // latch head entry and slice length
    logic slice_commit;  // write back the slice, load the result
    logic emit_empty;    // load a "nothing left" result
  } rrs_cmd_t;

  typedef struct packed {
    logic finished_all;
    logic ready_empty;
    logic scan_last;
    logic scan_found;
    logic out_free;
  } rrs_stat_t;

endpackage

`default_nettype wire

/* design/rrs_ctrl.sv */
// Scheduler controller: sequences decode, table scans, slice setup and write-back.
`default_nettype none

module rrs_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  input  logic [rrs_pkg::KIND_W-1:0]  kind,
  output logic                        item_stall,
  input  rrs_pkg::rrs_stat_t          stat,
  output rrs_pkg::rrs_cmd_t           cmd
);
  import rrs_pkg::*;

  localparam logic [3:0] S_IDLE        = 4'd0;
  localparam logic [3:0] S_CHECK       = 4'd1;
  localparam logic [3:0] S_EARLY       = 4'd2;
  localparam logic [3:0] S_ADMIT_IDLE  = 4'd3;
  localparam logic [3:0] S_POST_IDLE   = 4'd4;
  localparam logic [3:0] S_SLICE       = 4'd5;
  localparam logic [3:0] S_ADMIT_SLICE = 4'd6;
  localparam logic [3:0] S_COMMIT      = 4'd7;
  localparam logic [3:0] S_EMPTY       = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign item_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          unique case (kind)
            KIND_CLEAR: cmd.do_clear = 1'b1;
            KIND_LOAD:  cmd.do_load  = 1'b1;
            KIND_RUN: begin
              cmd.run_begin = 1'b1;
              state_next    = S_CHECK;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        if (stat.finished_all) begin
          state_next = S_EMPTY;
        end else if (stat.ready_empty) begin
          state_next = S_EARLY;
        end else begin
          state_next = S_SLICE;
        end
      end
      S_EARLY: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          cmd.time_jump = 1'b1;
          state_next    = S_ADMIT_IDLE;
        end
      end
      S_ADMIT_IDLE: begin
        cmd.scan_step    = 1'b1;
        cmd.scan_limited = 1'b1;
        if (stat.scan_last) begin
          if (stat.scan_found) begin
            cmd.admit_push = 1'b1;
          end else begin
            state_next = S_POST_IDLE;
          end
        end
      end
      S_POST_IDLE: begin
        state_next = stat.ready_empty ? S_EMPTY : S_SLICE;
      end
      S_SLICE: begin
        cmd.slice_setup = 1'b1;
        state_next      = S_ADMIT_SLICE;
      end
      S_ADMIT_SLICE: begin
        cmd.scan_step    = 1'b1;
        cmd.scan_limited = 1'b1;
        cmd.limit_sel    = 1'b1;
        if (stat.scan_last) begin
          if (stat.scan_found) begin
            cmd.admit_push = 1'b1;
          end else begin
            state_next = S_COMMIT;
          end
        end
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.slice_commit = 1'b1;
          state_next       = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (stat.out_free) begin
          cmd.emit_empty = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* design/rrs_dp.sv */
// Scheduler datapath: process table, ready queue, scan unit, time and result register.
`default_nettype none

module rrs_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  rrs_pkg::rrs_cmd_t            cmd,
  output rrs_pkg::rrs_stat_t           stat,
  input  logic [rrs_pkg::QNT_W-1:0]    quantum,
  input  logic [rrs_pkg::PID_W-1:0]    proc_id,
  input  logic [rrs_pkg::ARR_W-1:0]    arrival_time,
  input  logic [rrs_pkg::BURST_W-1:0]  burst_time,
  input  logic                         result_stall,
  output logic                         result_valid,
  output logic                         status,
  output logic [rrs_pkg::PID_W-1:0]    slice_proc_id,
  output logic [rrs_pkg::TIME_W-1:0]   slice_start,
  output logic [rrs_pkg::TIME_W-1:0]   slice_finish,
  output logic                         proc_finished,
  output logic [rrs_pkg::TIME_W-1:0]   total_waiting,
  output logic [rrs_pkg::TIME_W-1:0]   turnaround
);
  import rrs_pkg::*;

  // process table
  logic [ARR_W-1:0]   tbl_arrival    [MAX_PROCS];
  logic [PID_W-1:0]   tbl_pid        [MAX_PROCS];
  logic [BURST_W-1:0] tbl_remaining  [MAX_PROCS];
  logic [TIME_W-1:0]  tbl_last_pause [MAX_PROCS];
  logic [TIME_W-1:0]  tbl_waiting    [MAX_PROCS];
  logic [TIME_W-1:0]  tbl_turnaround [MAX_PROCS];
  logic [MAX_PROCS-1:0] admitted_mask;

  // ready queue
  logic [IDX_W-1:0] ready_fifo [MAX_PROCS];
  logic [IDX_W-1:0] ready_head;
  logic [CNT_W-1:0] ready_count;

  logic [CNT_W-1:0]  loaded_count;
  logic [CNT_W-1:0]  finished_count;
  logic [TIME_W-1:0] current_time;
  logic              run_started;

  // scan unit
  logic [IDX_W-1:0] scan_idx;
  logic             best_found;
  logic [IDX_W-1:0] best_idx;
  logic [ARR_W-1:0] best_arr;

  // slice in flight
  logic [IDX_W-1:0]   sl_idx;
  logic [TIME_W-1:0]  sl_finish;
  logic [BURST_W-1:0] sl_rem_new;

  logic               load_ok;
  logic               scan_last;
  logic               scan_valid;
  logic [ARR_W-1:0]   cur_arr;
  logic [TIME_W-1:0]  limit;
  logic               in_limit;
  logic               take_cur;
  logic               fin_found;
  logic [IDX_W-1:0]   fin_idx;
  logic [ARR_W-1:0]   fin_arr;
  logic [IDX_W-1:0]   tail_pos;
  logic [IDX_W-1:0]   head_pop;
  logic [IDX_W-1:0]   head_idx;
  logic [QNT_W-1:0]   q_eff;
  logic [BURST_W-1:0] rem_head;
  logic [BURST_W-1:0] amount;
  logic               sl_done;
  logic [TIME_W-1:0]  lp_sl;
  logic [TIME_W-1:0]  wait_new;
  logic [TIME_W-1:0]  turn_new;

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(MAX_PROCS)) begin
      sum = sum - (CNT_W+1)'(MAX_PROCS);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign load_ok    = !run_started && (loaded_count < CNT_W'(MAX_PROCS));

  // one table entry per cycle; winner is oldest arrival, lowest index on ties
  assign scan_last  = (scan_idx == IDX_W'(MAX_PROCS - 1));
  assign scan_valid = (CNT_W'(scan_idx) < loaded_count);
  assign cur_arr    = tbl_arrival[scan_idx];
  assign limit      = cmd.limit_sel ? sl_finish : current_time;
  assign in_limit   = !cmd.scan_limited || (TIME_W'(cur_arr) <= limit);
  assign take_cur   = scan_valid && !admitted_mask[scan_idx] && in_limit &&
                      (!best_found || (cur_arr < best_arr));
  assign fin_found  = best_found || take_cur;
  assign fin_idx    = take_cur ? scan_idx : best_idx;
  assign fin_arr    = take_cur ? cur_arr : best_arr;

  assign tail_pos = wrap_add(ready_head, ready_count);
  assign head_pop = wrap_add(ready_head, CNT_W'(1));
  assign head_idx = ready_fifo[ready_head];

  assign q_eff    = (quantum == '0) ? QNT_W'(1) : quantum;
  assign rem_head = tbl_remaining[head_idx];
  assign amount   = (rem_head < q_eff) ? rem_head : q_eff;

  assign sl_done  = (sl_rem_new == '0);
  assign lp_sl    = tbl_last_pause[sl_idx];
  assign wait_new = tbl_waiting[sl_idx] + (current_time - lp_sl);
  assign turn_new = tbl_turnaround[sl_idx] + (sl_finish - lp_sl);

  assign stat.finished_all = (finished_count >= loaded_count);
  assign stat.ready_empty  = (ready_count == '0);
  assign stat.scan_last    = scan_last;
  assign stat.scan_found   = fin_found;
  assign stat.out_free     = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      admitted_mask  <= '0;
      ready_head     <= '0;
      ready_count    <= '0;
      loaded_count   <= '0;
      finished_count <= '0;
      current_time   <= '0;
      run_started    <= 1'b0;
      scan_idx       <= '0;
      best_found     <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (cmd.do_clear) begin
        admitted_mask  <= '0;
        ready_head     <= '0;
        ready_count    <= '0;
        loaded_count   <= '0;
        finished_count <= '0;
        current_time   <= '0;
        run_started    <= 1'b0;
      end
      if (cmd.do_load && load_ok) begin
        loaded_count <= loaded_count + CNT_W'(1);
      end
      if (cmd.run_begin) begin
        run_started <= 1'b1;
      end
      if (cmd.scan_step) begin
        if (scan_last) begin
          scan_idx   <= '0;
          best_found <= 1'b0;
        end else begin
          scan_idx   <= scan_idx + IDX_W'(1);
          best_found <= fin_found;
        end
      end
      if (cmd.time_jump && fin_found && (TIME_W'(fin_arr) > current_time)) begin
        current_time <= TIME_W'(fin_arr);
      end
      if (cmd.admit_push) begin
        admitted_mask <= admitted_mask | (MAX_PROCS'(1) << fin_idx);
        ready_count   <= ready_count + CNT_W'(1);
      end
      if (cmd.slice_commit) begin
        // pop the head; an unfinished process goes back to the tail
        ready_head   <= head_pop;
        current_time <= sl_finish;
        if (sl_done) begin
          finished_count <= finished_count + CNT_W'(1);
          ready_count    <= ready_count - CNT_W'(1);
        end
      end
      if (cmd.slice_commit || cmd.emit_empty) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_load && load_ok) begin
      tbl_pid[loaded_count[IDX_W-1:0]]        <= proc_id;
      tbl_arrival[loaded_count[IDX_W-1:0]]    <= arrival_time;
      tbl_remaining[loaded_count[IDX_W-1:0]]  <= burst_time;
      tbl_last_pause[loaded_count[IDX_W-1:0]] <= TIME_W'(arrival_time);
      tbl_waiting[loaded_count[IDX_W-1:0]]    <= '0;
      tbl_turnaround[loaded_count[IDX_W-1:0]] <= '0;
    end
    if (cmd.scan_step) begin
      best_idx <= fin_idx;
      best_arr <= fin_arr;
    end
    if (cmd.admit_push) begin
      ready_fifo[tail_pos] <= fin_idx;
    end
    if (cmd.slice_setup) begin
      sl_idx     <= head_idx;
      sl_finish  <= current_time + TIME_W'(amount);
      sl_rem_new <= rem_head - amount;
    end
    if (cmd.slice_commit) begin
      tbl_remaining[sl_idx]  <= sl_rem_new;
      tbl_last_pause[sl_idx] <= sl_finish;
      tbl_waiting[sl_idx]    <= wait_new;
      tbl_turnaround[sl_idx] <= turn_new;
      if (!sl_done) begin
        ready_fifo[tail_pos] <= sl_idx;
      end
      status        <= 1'b0;
      slice_proc_id <= tbl_pid[sl_idx];
      slice_start   <= current_time;
      slice_finish  <= sl_finish;
      proc_finished <= sl_done;
      total_waiting <= wait_new;
      turnaround    <= turn_new;
    end
    if (cmd.emit_empty) begin
      status        <= 1'b1;
      slice_proc_id <= '0;
      slice_start   <= '0;
      slice_finish  <= '0;
      proc_finished <= 1'b0;
      total_waiting <= '0;
      turnaround    <= '0;
    end
  end

endmodule

`default_nettype wire

/* design/round_robin_scheduler.sv */
// Round-robin scheduler top level: quantum register, controller and datapath.
`default_nettype none

// Channel   Handshake                    Word contents
// item      item_valid / item_stall      kind, proc_id, arrival_time, burst_time
// result    result_valid / result_stall  status, slice_proc_id, slice_start,
//                                        slice_finish, proc_finished,
//                                        total_waiting, turnaround
// config    APB (psel/penable/pwrite)    quantum at byte address 0
//
// Clear and load words produce no result word.
// A run word then holds item_stall through the check, slice setup, a table scan
// for each process admitted during the slice plus a final one, and write-back;
// an empty queue first adds a time-jump scan and such a scan run for the
// processes admitted then. Each scan steps through the table one entry per cycle.
// Synchronous reset clears all counters, the run flag and the result valid;
// quantum returns to 4. Table contents are not cleared.
// A result word waits in its output register; further clear/load words are
// taken meanwhile, and the next run holds its write-back until it is taken.

module round_robin_scheduler (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [rrs_pkg::KIND_W-1:0]        kind,
  input  logic [rrs_pkg::PID_W-1:0]         proc_id,
  input  logic [rrs_pkg::ARR_W-1:0]         arrival_time,
  input  logic [rrs_pkg::BURST_W-1:0]       burst_time,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              status,
  output logic [rrs_pkg::PID_W-1:0]         slice_proc_id,
  output logic [rrs_pkg::TIME_W-1:0]        slice_start,
  output logic [rrs_pkg::TIME_W-1:0]        slice_finish,
  output logic                              proc_finished,
  output logic [rrs_pkg::TIME_W-1:0]        total_waiting,
  output logic [rrs_pkg::TIME_W-1:0]        turnaround,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rrs_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [rrs_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [rrs_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import rrs_pkg::*;

  logic [QNT_W-1:0] quantum;
  logic             quantum_sel;
  rrs_cmd_t         cmd;
  rrs_stat_t        stat;

  // config register: quantum only; zero behaves as a quantum of one
  assign pready      = 1'b1;
  assign quantum_sel = (paddr[APB_ADDR_W-1:2] == REG_QUANTUM);
  assign prdata      = quantum_sel ? APB_DATA_W'(quantum) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QUANTUM_RESET;
    end else if (psel && penable && pwrite && pready && quantum_sel) begin
      quantum <= pwdata[QNT_W-1:0];
    end
  end

  rrs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .kind       (kind),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  rrs_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .quantum       (quantum),
    .proc_id       (proc_id),
    .arrival_time  (arrival_time),
    .burst_time    (burst_time),
    .result_stall  (result_stall),
    .result_valid  (result_valid),
    .status        (status),
    .slice_proc_id (slice_proc_id),
    .slice_start   (slice_start),
    .slice_finish  (slice_finish),
    .proc_finished (proc_finished),
    .total_waiting (total_waiting),
    .turnaround    (turnaround)
  );

  // clear and load words never raise a result
  a_no_result_from_setup: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && (kind != KIND_RUN)) |=> !$rose(result_valid))
    else $error("result raised by a non-run word");

  // a run word keeps the input stalled while the slice is worked out
  a_run_stalls: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && (kind == KIND_RUN)) |=> item_stall)
    else $error("run word did not occupy the engine");

  // "nothing left" words carry all-zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status) |-> (slice_proc_id == '0) && (slice_start == '0) &&
      (slice_finish == '0) && !proc_finished && (total_waiting == '0) &&
      (turnaround == '0))
    else $error("empty result with nonzero fields");

  // a slice never ends before it starts
  a_slice_order: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !status) |-> (slice_finish >= slice_start))
    else $error("slice finish before start");

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the round-robin scheduler: stimulus, slice prediction, checks.
`timescale 1ns / 100ps

import rrs_pkg::*;

// One result word as the scheduler reports it.
typedef struct packed {
  logic              status;
  logic [PID_W-1:0]  pid;
  logic [TIME_W-1:0] start;
  logic [TIME_W-1:0] finish;
  logic              done;
  logic [TIME_W-1:0] waiting;
  logic [TIME_W-1:0] tat;
} slice_word_t;

// Tracks the process table and predicts every slice; checks result words against it.
class rr_slice_board;
  logic [TIME_W-1:0]  arrival    [MAX_PROCS];
  logic [PID_W-1:0]   pid        [MAX_PROCS];
  logic [BURST_W-1:0] remaining  [MAX_PROCS];
  logic [TIME_W-1:0]  last_pause [MAX_PROCS];
  logic [TIME_W-1:0]  waiting    [MAX_PROCS];
  logic [TIME_W-1:0]  tat        [MAX_PROCS];
  logic [MAX_PROCS-1:0] admitted;
  int                 ready_order[$];
  int                 loaded;
  int                 finished;
  logic [TIME_W-1:0]  now;
  bit                 started;
  logic [QNT_W-1:0]   quantum;
  slice_word_t        expected_slices[$];
  int unsigned        errors;

  function new();
    quantum = QUANTUM_RESET;
    errors  = 0;
    clear_table();
  endfunction

  function void clear_table();
    admitted = '0;
    ready_order.delete();
    loaded   = 0;
    finished = 0;
    now      = '0;
    started  = 1'b0;
  endfunction

  function void set_quantum(logic [QNT_W-1:0] q);
    quantum = q;
  endfunction

  function bit all_finished();
    return finished >= loaded;
  endfunction

  // Queue every pending process arrived by the limit, oldest first, ties in load order.
  function void admit_arrivals(logic [TIME_W-1:0] limit);
    int best;
    forever begin
      best = -1;
      for (int i = 0; i < loaded; i++) begin
        if (admitted[i] || arrival[i] > limit) continue;
        if (best < 0 || arrival[i] < arrival[best]) best = i;
      end
      if (best < 0) return;
      admitted[best] = 1'b1;
      if (ready_order.size() < MAX_PROCS) ready_order.push_back(best);
    end
  endfunction

  function slice_word_t predict_slice();
    slice_word_t       r;
    logic [TIME_W-1:0] earliest;
    logic [QNT_W-1:0]  q;
    logic [BURST_W-1:0] len;
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] t1;
    int                idx;
    r = '0;
    started = 1'b1;
    if (finished >= loaded) begin
      r.status = 1'b1;
      return r;
    end
    // idle CPU: jump to the earliest arrival still pending
    if (ready_order.size() == 0) begin
      earliest = '1;
      for (int i = 0; i < loaded; i++)
        if (!admitted[i] && arrival[i] < earliest) earliest = arrival[i];
      if (earliest > now) now = earliest;
      admit_arrivals(now);
    end
    if (ready_order.size() == 0) begin
      r.status = 1'b1;
      return r;
    end
    idx = ready_order[0];
    q   = (quantum == '0) ? QNT_W'(1) : quantum;
    len = (remaining[idx] < q) ? remaining[idx] : q;
    t0  = now;
    t1  = t0 + {8'b0, len};
    // new arrivals go ahead of the preempted process
    admit_arrivals(t1);
    tat[idx]        = tat[idx] + (t1 - last_pause[idx]);
    waiting[idx]    = waiting[idx] + (t0 - last_pause[idx]);
    last_pause[idx] = t1;
    remaining[idx]  = remaining[idx] - len;
    void'(ready_order.pop_front());
    if (remaining[idx] == '0) finished++;
    else ready_order.push_back(idx);
    now       = t1;
    r.pid     = pid[idx];
    r.start   = t0;
    r.finish  = t1;
    r.done    = (remaining[idx] == '0);
    r.waiting = waiting[idx];
    r.tat     = tat[idx];
    return r;
  endfunction

  // Called for every word the scheduler accepts.
  function void note_word(logic [KIND_W-1:0] k, logic [PID_W-1:0] p,
                          logic [ARR_W-1:0] a, logic [BURST_W-1:0] b);
    case (k)
      KIND_CLEAR: clear_table();
      KIND_LOAD: begin
        if (!started && loaded < MAX_PROCS) begin
          pid[loaded]        = p;
          arrival[loaded]    = {4'b0, a};
          remaining[loaded]  = b;
          last_pause[loaded] = {4'b0, a};
          waiting[loaded]    = '0;
          tat[loaded]        = '0;
          loaded++;
        end
      end
      KIND_RUN: expected_slices.push_back(predict_slice());
      default: ;
    endcase
  endfunction

  function void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_slice(slice_word_t got);
    slice_word_t want;
    if (expected_slices.size() == 0) begin
      $display("%0t: unexpected result word: status %0d pid %0d start %0d finish %0d",
               $time, got.status, got.pid, got.start, got.finish);
      errors++;
      return;
    end
    want = expected_slices.pop_front();
    check_field("status", want.status, got.status);
    check_field("slice_proc_id", want.pid, got.pid);
    check_field("slice_start", want.start, got.start);
    check_field("slice_finish", want.finish, got.finish);
    check_field("proc_finished", want.done, got.done);
    check_field("total_waiting", want.waiting, got.waiting);
    check_field("turnaround", want.tat, got.tat);
  endfunction
endclass

module tb;

  // Quiet time before a register write or the end, taken with margin over the worst run word.
  localparam int SETTLE_CYCLES  = 200;
  // Watchdog limit: covers the ~1700 words of a run plus stalls, several times over.
  localparam int LIMIT_CYCLES   = 2_000_000;
  localparam int RANDOM_PHASES  = 8;
  localparam int WORDS_PER_PHASE = 206;
  localparam logic [APB_ADDR_W-1:0] QUANTUM_ADDR = {REG_QUANTUM, 2'b00};

  logic                  clk;
  logic                  rst;
  logic                  item_valid;
  logic                  item_stall;
  logic [KIND_W-1:0]     kind;
  logic [PID_W-1:0]      proc_id;
  logic [ARR_W-1:0]      arrival_time;
  logic [BURST_W-1:0]    burst_time;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic                  status;
  logic [PID_W-1:0]      slice_proc_id;
  logic [TIME_W-1:0]     slice_start;
  logic [TIME_W-1:0]     slice_finish;
  logic                  proc_finished;
  logic [TIME_W-1:0]     total_waiting;
  logic [TIME_W-1:0]     turnaround;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rr_slice_board sb;
  int unsigned   sender_pct = 0;   // chance per cycle that the sender holds off
  int unsigned   stall_pct  = 0;   // chance per cycle that the result side stalls
  int            words_sent = 0;
  int            stop_at    = 0;   // word count at which the current phase ends
  int            cycle_count = 0;

  round_robin_scheduler dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .kind          (kind),
    .proc_id       (proc_id),
    .arrival_time  (arrival_time),
    .burst_time    (burst_time),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .status        (status),
    .slice_proc_id (slice_proc_id),
    .slice_start   (slice_start),
    .slice_finish  (slice_finish),
    .proc_finished (proc_finished),
    .total_waiting (total_waiting),
    .turnaround    (turnaround),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Result side: random stall, changed only on the falling edge.
  always @(negedge clk) begin
    result_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // Result monitor: a word moves on a rising edge with valid high and stall low.
  always @(posedge clk) begin
    slice_word_t got;
    if (!rst && result_valid === 1'b1 && !result_stall) begin
      got.status  = status;
      got.pid     = slice_proc_id;
      got.start   = slice_start;
      got.finish  = slice_finish;
      got.done    = proc_finished;
      got.waiting = total_waiting;
      got.tat     = turnaround;
      sb.check_slice(got);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("round_robin_scheduler regression: fail");
      $finish;
    end
  end

  // Entered and left on a falling edge. Valid stays high straight into the next
  // word unless the sender decides to hold off; the payload is held while stalled.
  task automatic send_word(input logic [KIND_W-1:0] k, input logic [PID_W-1:0] p,
                           input logic [ARR_W-1:0] a, input logic [BURST_W-1:0] b);
    while (sender_pct != 0 && $urandom_range(0, 99) < sender_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid   <= 1'b1;
    kind         <= k;
    proc_id      <= p;
    arrival_time <= a;
    burst_time   <= b;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_word(k, p, a, b);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_run();
    send_word(KIND_RUN, PID_W'($urandom), ARR_W'($urandom), BURST_W'($urandom));
  endtask

  task automatic send_clear();
    send_word(KIND_CLEAR, PID_W'($urandom), ARR_W'($urandom), BURST_W'($urandom));
  endtask

  // Sender goes quiet until every predicted slice has come back.
  task automatic drain_results();
    item_valid <= 1'b0;
    @(negedge clk);
    while (sb.expected_slices.size() != 0) @(negedge clk);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [APB_ADDR_W-1:0] addr, output logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Quantum changes only with the scheduler idle: results drained, then a quiet
  // stretch so any trailing clear/load has settled. Read back to check the register.
  task automatic program_quantum(input logic [QNT_W-1:0] q);
    logic [APB_DATA_W-1:0] rd;
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    apb_write(QUANTUM_ADDR, {24'b0, q});
    @(negedge clk);
    apb_read(QUANTUM_ADDR, rd);
    sb.check_field("quantum readback", q, rd);
    sb.set_quantum(q);
  endtask

  // One well-formed job set most of the time: clear, load, run to completion, a
  // stray run or two after. Sprinkled with noise words, overfull tables, loads
  // after the run began and clears in the middle of a run.
  task automatic random_set();
    int                 n;
    int                 style;
    logic [ARR_W-1:0]   a;
    logic [BURST_W-1:0] b;
    if ($urandom_range(0, 5) == 0) drain_results();
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 6))
        send_word(KIND_W'($urandom_range(0, 2)), PID_W'($urandom), ARR_W'($urandom),
                  BURST_W'($urandom_range(1, 255)));
    if ($urandom_range(0, 11) != 0) send_clear();
    n     = ($urandom_range(0, 7) == 0) ? $urandom_range(MAX_PROCS + 1, MAX_PROCS + 3)
                                        : $urandom_range(1, MAX_PROCS);
    style = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      case (style)
        0:       a = ARR_W'($urandom_range(0, 15));      // bunched, lots of ties
        1:       a = ARR_W'($urandom_range(0, 4095));    // sparse, forces time jumps
        2:       a = ARR_W'($urandom_range(0, 300));
        default: a = ARR_W'($urandom_range(0, 3) * 20);  // exact ties
      endcase
      // long bursts only where the quantum keeps the slice count sane
      if (sb.quantum >= 8 && $urandom_range(0, 15) == 0) b = BURST_W'($urandom_range(1, 255));
      else b = BURST_W'($urandom_range(1, 12));
      send_word(KIND_LOAD, PID_W'($urandom), a, b);
    end
    while (!sb.all_finished() && words_sent < stop_at) begin
      case ($urandom_range(0, 39))
        0:       send_word(KIND_LOAD, PID_W'($urandom), ARR_W'($urandom),
                           BURST_W'($urandom_range(1, 255)));
        1:       send_clear();
        default: send_run();
      endcase
    end
    repeat ($urandom_range(0, 2)) send_run();
  endtask

  initial begin
    logic [APB_DATA_W-1:0]  rd;
    logic [QNT_W-1:0]       phase_quantum [RANDOM_PHASES];
    int unsigned            phase_sender  [4];
    int unsigned            phase_stall   [4];

    sb = new();
    rst          = 1'b1;
    item_valid   = 1'b0;
    kind         = KIND_CLEAR;
    proc_id      = '0;
    arrival_time = '0;
    burst_time   = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;

    // idle modes: none, sender only, receiver only, both
    phase_sender = '{0, 49, 0, 36};
    phase_stall  = '{0, 0, 49, 36};
    phase_quantum = '{8'd1, 8'd255, 8'd2, QNT_W'($urandom_range(1, 255)),
                      8'd5, 8'd128, QNT_W'($urandom_range(1, 255)), 8'd4};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    apb_read(QUANTUM_ADDR, rd);
    sb.check_field("quantum after reset", QUANTUM_RESET, rd);

    // ---- directed part, quantum at its reset value ----
    send_run();                                   // nothing loaded: done status
    send_word(KIND_LOAD, 8'hFF, 12'd4095, 8'd255); // dropped, run already begun
    send_run();
    send_clear();
    // fill the table past capacity; extremes of every field, ties at zero
    send_word(KIND_LOAD, 8'h00, 12'd4095, 8'd255);
    send_word(KIND_LOAD, 8'hFF, 12'd0, 8'd1);
    send_word(KIND_LOAD, 8'hA5, 12'd0, 8'd2);
    send_word(KIND_LOAD, 8'h5A, 12'd7, 8'd255);
    send_word(KIND_LOAD, 8'h3C, 12'd3, 8'd170);
    send_word(KIND_LOAD, 8'hC3, 12'd2048, 8'd85);
    send_word(KIND_LOAD, 8'h0F, 12'd1, 8'd4);
    send_word(KIND_LOAD, 8'hF0, 12'd2730, 8'd9);
    send_word(KIND_LOAD, 8'h77, 12'd0, 8'd1);      // ninth: table full, dropped
    send_run();
    send_run();
    send_clear();
    // two ties at zero, then a gap that forces a time jump once the queue empties
    send_word(KIND_LOAD, 8'h12, 12'd0, 8'd6);
    send_word(KIND_LOAD, 8'h34, 12'd0, 8'd3);
    send_word(KIND_LOAD, 8'h56, 12'd50, 8'd1);
    while (!sb.all_finished()) send_run();
    send_run();                                   // everything finished: done status

    // ---- random part: one phase per quantum setting, idle mode rotating ----
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      program_quantum(phase_quantum[ph]);
      sender_pct = phase_sender[ph % 4];
      stall_pct  = phase_stall[ph % 4];
      stop_at    = words_sent + WORDS_PER_PHASE;
      while (words_sent < stop_at) random_set();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_slices.size() == 0) begin
      $display("round_robin_scheduler regression: pass");
    end else begin
      $display("round_robin_scheduler regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/rrs_pkg.sv
design/rrs_ctrl.sv
design/rrs_dp.sv
design/round_robin_scheduler.sv
verif/tb.sv
